// File: sv/ars_pkg.sv
// ars_pkg: shared constants, control word types and the microcode table
// for the adaptive rate sampler. No dependencies.
`timescale 1ns / 1ps

package ars_pkg;

  localparam int COUNT_WIDTH_DEF = 48;
  localparam int TS_W            = 63;
  localparam int INTERVAL_W      = 12;
  localparam int DIV_W           = 64;
  localparam int NUM_W           = 42;
  localparam int PC_W            = 4;
  localparam int WARMUP_SLOW     = 10;
  localparam int WARMUP_FAST     = 1000;
  localparam int STEP_CAP        = 1000;
  localparam logic [29:0] NS_PER_SEC = 30'd1000000000;

  typedef enum logic {
    REG_INTERVAL = 1'b0,
    REG_FAST     = 1'b1
  } reg_index_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_CLASSIFY,
    OP_DELTA,
    OP_DIV_PER,
    OP_TAKE_PER,
    OP_DIV_STEP,
    OP_TAKE_STEP,
    OP_STEP_MAX,
    OP_SCHEDULE,
    OP_FIRST_BASE,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_ITEM,
    C_NOT_ADV,
    C_DC_ZERO,
    C_DIV_BUSY,
    C_PER_ZERO,
    C_OUT_BLOCKED
  } cond_t;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic [PC_W-1:0]  target;
  } ctrl_word_t;

  typedef struct packed {
    logic not_adv;
    logic dc_zero;
    logic per_zero;
    logic div_busy;
    logic out_blocked;
  } status_t;

  // After a step runs: jump to target if cond holds, else advance.
  function automatic ctrl_word_t ucode_rom(input logic [PC_W-1:0] pc);
    ctrl_word_t w;
    w = '{op: OP_NONE, cond: C_ALWAYS, target: PC_W'(0)};
    case (pc)
      PC_W'(0):  w = '{op: OP_ACCEPT,     cond: C_NO_ITEM,     target: PC_W'(0)};
      PC_W'(1):  w = '{op: OP_CLASSIFY,   cond: C_NOT_ADV,     target: PC_W'(13)};
      PC_W'(2):  w = '{op: OP_DELTA,      cond: C_DC_ZERO,     target: PC_W'(6)};
      PC_W'(3):  w = '{op: OP_DIV_PER,    cond: C_NEVER,       target: PC_W'(0)};
      PC_W'(4):  w = '{op: OP_NONE,       cond: C_DIV_BUSY,    target: PC_W'(4)};
      PC_W'(5):  w = '{op: OP_TAKE_PER,   cond: C_NEVER,       target: PC_W'(0)};
      PC_W'(6):  w = '{op: OP_NONE,       cond: C_PER_ZERO,    target: PC_W'(10)};
      PC_W'(7):  w = '{op: OP_DIV_STEP,   cond: C_NEVER,       target: PC_W'(0)};
      PC_W'(8):  w = '{op: OP_NONE,       cond: C_DIV_BUSY,    target: PC_W'(8)};
      PC_W'(9):  w = '{op: OP_TAKE_STEP,  cond: C_ALWAYS,      target: PC_W'(11)};
      PC_W'(10): w = '{op: OP_STEP_MAX,   cond: C_NEVER,       target: PC_W'(0)};
      PC_W'(11): w = '{op: OP_SCHEDULE,   cond: C_ALWAYS,      target: PC_W'(15)};
      PC_W'(13): w = '{op: OP_FIRST_BASE, cond: C_ALWAYS,      target: PC_W'(15)};
      PC_W'(15): w = '{op: OP_EMIT,       cond: C_OUT_BLOCKED, target: PC_W'(15)};
      default:   w = '{op: OP_NONE,       cond: C_ALWAYS,      target: PC_W'(0)};
    endcase
    return w;
  endfunction

endpackage

// File: sv/ars_sequencer.sv
// ars_sequencer: step counter and microcode fetch with conditional jumps.
// Depends on ars_pkg for the control word, status and microcode table.
`timescale 1ns / 1ps

module ars_sequencer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  ars_pkg::status_t    status,
  output ars_pkg::ctrl_word_t ctrl,
  output logic                in_ready
);

  logic [ars_pkg::PC_W-1:0] pc_r;
  logic [ars_pkg::PC_W-1:0] pc_nxt;
  logic                     take_jump;

  always_comb begin
    ctrl     = ars_pkg::ucode_rom(pc_r);
    in_ready = (ctrl.op == ars_pkg::OP_ACCEPT);
    case (ctrl.cond)
      ars_pkg::C_NEVER:       take_jump = 1'b0;
      ars_pkg::C_ALWAYS:      take_jump = 1'b1;
      ars_pkg::C_NO_ITEM:     take_jump = !in_valid;
      ars_pkg::C_NOT_ADV:     take_jump = status.not_adv;
      ars_pkg::C_DC_ZERO:     take_jump = status.dc_zero;
      ars_pkg::C_DIV_BUSY:    take_jump = status.div_busy;
      ars_pkg::C_PER_ZERO:    take_jump = status.per_zero;
      ars_pkg::C_OUT_BLOCKED: take_jump = status.out_blocked;
      default:                take_jump = 1'b0;
    endcase
    // the last step wraps to the first
    pc_nxt = take_jump ? ctrl.target : pc_r + ars_pkg::PC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// File: sv/ars_divider.sv
// ars_divider: unsigned restoring divider, one quotient bit per cycle.
// Depends on ars_pkg for the operand width.
`timescale 1ns / 1ps

module ars_divider (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [ars_pkg::DIV_W-1:0] dividend,
  input  logic [ars_pkg::DIV_W-1:0] divisor,
  output logic                      busy,
  output logic [ars_pkg::DIV_W-1:0] quotient
);

  localparam int W   = ars_pkg::DIV_W;
  localparam int CNT_W = $clog2(W + 1);

  logic [W-1:0]     rem_r, rem_nxt;
  logic [W-1:0]     quo_r, quo_nxt;
  logic [W-1:0]     dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic [W:0]       trial;
  logic             fits;

  always_comb begin
    trial   = {rem_r, quo_r[W-1]};
    fits    = (trial >= {1'b0, dvs_r});
    rem_nxt = fits ? W'(trial - {1'b0, dvs_r}) : trial[W-1:0];
    quo_nxt = {quo_r[W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(W);
    end else if (busy_r) begin
      cnt_r  <= cnt_r - CNT_W'(1);
      busy_r <= (cnt_r != CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

// File: sv/ars_datapath.sv
// ars_datapath: counters, base, schedule, config and output registers,
// driven one control word per cycle. Depends on ars_pkg and ars_divider.
`timescale 1ns / 1ps

module ars_datapath #(
  parameter int COUNT_WIDTH = ars_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ars_pkg::ctrl_word_t            ctrl,
  input  logic                           in_valid,
  input  logic [ars_pkg::TS_W-1:0]       in_timestamp_ns,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [ars_pkg::INTERVAL_W-1:0] cfg_wdata,
  input  logic                           out_ready,
  output ars_pkg::status_t               status,
  output logic                           out_valid,
  output logic                           out_sampled,
  output logic [ars_pkg::TS_W-1:0]       out_elapsed_ns,
  output logic                           out_too_fast
);

  localparam int CW = COUNT_WIDTH;
  localparam int TW = ars_pkg::TS_W;
  localparam int DW = ars_pkg::DIV_W;
  localparam logic [DW-1:0] CMAX_WIDE = {DW{1'b1}} >> (DW - CW);

  logic [ars_pkg::INTERVAL_W-1:0] interval_r;
  logic                           fast_r;
  logic [TW-1:0]                  ts_r;
  logic [CW-1:0]                  ec_r;
  logic                           base_valid_r;
  logic [TW-1:0]                  base_time_r;
  logic [CW-1:0]                  base_count_r;
  logic                           sched_valid_r;
  logic [CW-1:0]                  nsc_r;
  logic                           hit_r;
  logic                           too_fast_r;
  logic [TW-1:0]                  dt_r;
  logic [CW-1:0]                  dc_r;
  logic [DW-1:0]                  per_r;
  logic [CW-1:0]                  step_r;
  logic                           out_valid_r;
  logic                           out_sampled_r;
  logic [TW-1:0]                  out_elapsed_r;
  logic                           out_too_fast_r;

  logic [TW-1:0]                  dt_c;
  logic [CW-1:0]                  dc_c;
  logic [CW-1:0]                  warmup_c;
  logic                           hit_c;
  logic                           est_c;
  logic [CW-1:0]                  step_c;
  logic [ars_pkg::NUM_W-1:0]      num_c;
  logic                           div_start;
  logic [DW-1:0]                  div_dividend;
  logic [DW-1:0]                  div_divisor;
  logic                           div_busy;
  logic [DW-1:0]                  div_quotient;
  logic                           out_free;

  always_comb begin
    dt_c     = (ts_r >= base_time_r) ? ts_r - base_time_r : '0;
    dc_c     = ec_r - base_count_r;
    warmup_c = fast_r ? CW'(ars_pkg::WARMUP_FAST) : CW'(ars_pkg::WARMUP_SLOW);
    hit_c    = sched_valid_r && (ec_r > nsc_r);
    est_c    = !sched_valid_r && base_valid_r && (ec_r > warmup_c);
    step_c   = (!fast_r && (step_r > CW'(ars_pkg::STEP_CAP))) ?
               CW'(ars_pkg::STEP_CAP) : step_r;
    num_c    = ars_pkg::NUM_W'(interval_r) * ars_pkg::NUM_W'(ars_pkg::NS_PER_SEC);
    div_start    = (ctrl.op == ars_pkg::OP_DIV_PER) || (ctrl.op == ars_pkg::OP_DIV_STEP);
    div_dividend = (ctrl.op == ars_pkg::OP_DIV_PER) ? DW'(dt_r) : DW'(num_c);
    div_divisor  = (ctrl.op == ars_pkg::OP_DIV_PER) ? DW'(dc_r) : per_r;
    out_free     = !out_valid_r || out_ready;
    status.not_adv     = !(hit_c || est_c);
    status.dc_zero     = (dc_c == '0);
    status.per_zero    = (per_r == '0);
    status.div_busy    = div_busy;
    status.out_blocked = !out_free;
  end

  ars_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_quotient)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= ars_pkg::INTERVAL_W'(1);
      fast_r     <= 1'b1;
    end else if (cfg_we) begin
      case (ars_pkg::reg_index_t'(cfg_index))
        ars_pkg::REG_INTERVAL: interval_r <= cfg_wdata;
        ars_pkg::REG_FAST:     fast_r     <= cfg_wdata[0];
        default:               fast_r     <= fast_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ec_r          <= '0;
      base_valid_r  <= 1'b0;
      base_time_r   <= '0;
      base_count_r  <= '0;
      sched_valid_r <= 1'b0;
      nsc_r         <= '0;
    end else begin
      case (ctrl.op)
        ars_pkg::OP_ACCEPT: begin
          if (in_valid) begin
            ec_r <= ec_r + CW'(1);
          end
        end
        ars_pkg::OP_SCHEDULE: begin
          if (!sched_valid_r) begin
            if (step_c != '0) begin
              nsc_r         <= step_c - CW'(1);
              sched_valid_r <= 1'b1;
            end
          end else if (step_c > ~nsc_r) begin
            nsc_r <= '1;
          end else begin
            nsc_r <= nsc_r + step_c;
          end
          if (hit_r) begin
            base_time_r  <= ts_r;
            base_count_r <= ec_r;
          end
        end
        ars_pkg::OP_FIRST_BASE: begin
          if (!sched_valid_r && !base_valid_r) begin
            base_valid_r <= 1'b1;
            base_time_r  <= ts_r;
            base_count_r <= ec_r;
          end
        end
        default: begin
          ec_r <= ec_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      ars_pkg::OP_ACCEPT: begin
        if (in_valid) begin
          ts_r       <= in_timestamp_ns;
          too_fast_r <= 1'b0;
        end
      end
      ars_pkg::OP_CLASSIFY: hit_r <= hit_c;
      ars_pkg::OP_DELTA: begin
        dt_r       <= dt_c;
        dc_r       <= dc_c;
        too_fast_r <= (DW'(dt_c) < DW'(dc_c));
        per_r      <= '0;
      end
      ars_pkg::OP_TAKE_PER:  per_r <= div_quotient;
      ars_pkg::OP_TAKE_STEP: begin
        step_r <= (div_quotient > CMAX_WIDE) ? '1 : div_quotient[CW-1:0];
      end
      ars_pkg::OP_STEP_MAX:  step_r <= '1;
      default:               per_r  <= per_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.op == ars_pkg::OP_EMIT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == ars_pkg::OP_EMIT && out_free) begin
      out_sampled_r  <= hit_r;
      out_elapsed_r  <= hit_r ? dt_r : '0;
      out_too_fast_r <= too_fast_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sampled    = out_sampled_r;
  assign out_elapsed_ns = out_elapsed_r;
  assign out_too_fast   = out_too_fast_r;

endmodule

// File: sv/adaptive_rate_sampler.sv
// adaptive_rate_sampler: top level, joins the microcode sequencer and the
// datapath. Depends on ars_pkg, ars_sequencer and ars_datapath.
//
//   channel | ports                                  | direction
//   --------+----------------------------------------+----------
//   in      | in_valid, in_ready, in_timestamp_ns    | input item
//   out     | out_valid, out_ready, out_sampled,     | result item
//           | out_elapsed_ns, out_too_fast           |
//   cfg     | cfg_we, cfg_index, cfg_wdata           | register write
//
// With no estimate, an item runs the accept, classify, first-base and emit
// steps. An estimate runs up to two divisions, one after the other, on the
// shared serial divider, which gives one quotient bit per cycle.
// Reset is synchronous; the step counter returns to the accept step.
// The next item is taken while a result waits in the output register; the
// emit step holds until that register is free.
`timescale 1ns / 1ps

module adaptive_rate_sampler #(
  parameter int COUNT_WIDTH = ars_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [ars_pkg::TS_W-1:0]       in_timestamp_ns,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_sampled,
  output logic [ars_pkg::TS_W-1:0]       out_elapsed_ns,
  output logic                           out_too_fast,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [ars_pkg::INTERVAL_W-1:0] cfg_wdata
);

  ars_pkg::ctrl_word_t ctrl;
  ars_pkg::status_t    status;

  ars_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .status   (status),
    .ctrl     (ctrl),
    .in_ready (in_ready)
  );

  ars_datapath #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctrl            (ctrl),
    .in_valid        (in_valid),
    .in_timestamp_ns (in_timestamp_ns),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .out_ready       (out_ready),
    .status          (status),
    .out_valid       (out_valid),
    .out_sampled     (out_sampled),
    .out_elapsed_ns  (out_elapsed_ns),
    .out_too_fast    (out_too_fast)
  );

endmodule

// File: sv/ars_checker.sv
// ars_checker: port-level assertions for adaptive_rate_sampler and the
// bind that attaches them. Depends on ars_pkg for widths.
`timescale 1ns / 1ps

module ars_checker (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic                     out_sampled,
  input logic [ars_pkg::TS_W-1:0] out_elapsed_ns,
  input logic                     out_too_fast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sampled) &&
      $stable(out_elapsed_ns) && $stable(out_too_fast))
    else $error("result item changed while stalled");

  a_elapsed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_sampled |-> out_elapsed_ns == '0)
    else $error("elapsed time reported on an unsampled item");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while previous item in progress");

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not idle after reset");

endmodule

bind adaptive_rate_sampler ars_checker u_ars_checker (.*);
